/* rtl/tts_pkg.sv */
// Shared types and constants for the tick task scheduler core.
// No dependencies; used by tick_task_scheduler_core.
package tts_pkg;

	// Command codes (carried on s_tuser)
	localparam logic [2:0] CMD_TICK        = 3'd0;
	localparam logic [2:0] CMD_LOAD        = 3'd1;
	localparam logic [2:0] CMD_CLEAR_TASKS = 3'd2;
	localparam logic [2:0] CMD_CLEAR_FLAGS = 3'd3;
	localparam logic [2:0] CMD_SET_FLAGS   = 3'd4;

	// Radio modes
	localparam logic [2:0] MODE_FOREGROUND = 3'd0;
	localparam logic [2:0] MODE_TRANSMIT   = 3'd1;
	localparam logic [2:0] MODE_INCOMING   = 3'd3;
	localparam logic [2:0] MODE_RECEIVE    = 3'd4;
	localparam logic [2:0] MODE_POWER_SAVE = 3'd5;

	// Tone scan modes
	localparam logic [1:0] TONE_OFF      = 2'd0;
	localparam logic [1:0] TONE_SCANNING = 2'd1;

	// Task bit positions
	localparam int TASK_KEYS    = 0;
	localparam int TASK_IRQ     = 1;
	localparam int TASK_SCREEN  = 2;
	localparam int TASK_SCAN    = 3;
	localparam int TASK_FM      = 4;

	// Event flag bit positions
	localparam int FLAG_40MS    = 0;
	localparam int FLAG_500MS   = 1;
	localparam int FLAG_TXTO    = 2;
	localparam int FLAG_CDCSS   = 3;
	localparam int FLAG_CTCSS   = 4;
	localparam int FLAG_PSAVE   = 5;
	localparam int FLAG_SAVEEXP = 6;
	localparam int FLAG_DUALW   = 7;
	localparam int FLAG_SCANL   = 8;
	localparam int FLAG_TAIL    = 9;

	// Countdown indexes
	localparam int CD_TXTO  = 0;
	localparam int CD_CDCSS = 1;
	localparam int CD_CTCSS = 2;
	localparam int CD_SWAIT = 3;
	localparam int CD_SAVE  = 4;
	localparam int CD_DUALW = 5;
	localparam int CD_SCANP = 6;
	localparam int CD_TAIL  = 7;
	localparam int NUM_CD   = 8;

	localparam int TASK_W  = 5;
	localparam int FLAG_W  = 10;
	localparam int COUNT_W = 32;
	localparam int LOAD_W  = 16;
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;

	// Phase counter wrap points
	localparam logic [4:0] MOD21_LAST = 5'd20;
	localparam logic [5:0] MOD50_LAST = 6'd49;

	typedef struct packed {
		logic [9:0]  bit_mask;
		logic [15:0] load_value;
		logic [2:0]  timer_index;
		logic [1:0]  tone_scan_mode;
		logic        scan_active;
		logic        display_request;
		logic [2:0]  radio_mode;
	} in_fields_t;

	typedef struct packed {
		logic [COUNT_W-1:0] tick_count;
		logic [FLAG_W-1:0]  event_flags;
		logic [TASK_W-1:0]  task_bits;
	} out_fields_t;

endpackage

/* rtl/tick_task_scheduler_core.sv */
// Tick task scheduler core: command stream in, scheduler state snapshot out.
// Depends on tts_pkg (types, command codes, bit positions).

// One result item is returned for every command item, showing the task bits,
// event flags and tick count after the command. An accepted item is held in
// an input register; short logic then updates the scheduler state and loads
// the output register, so the core takes one item per clock while the output
// register is empty or being drained, and offers each result on m_tvalid.
// Both stages advance while the output register is empty or being drained, so
// a waiting result leaves room for one item in the input stage. Commands on
// s_tuser: tick, load countdown, clear tasks, clear flags, set flags; other
// codes leave the state unchanged. The 21-tick scanner period and the 50-tick
// slow period run from their own phase counters. Countdowns are TIMER_WIDTH
// bits; load values are truncated or zero-extended to that width. The
// dual-watch enable register is written through cfg_valid/cfg_data, always ready.
module tick_task_scheduler_core #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Configuration: dual-watch enable
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic                            cfg_data,
	// Command items
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// radio_mode[2:0], display_request[3], scan_active[4], tone_scan_mode[6:5],
	// timer_index[9:7], load_value[25:10], bit_mask[35:26], zero pad [39:36]
	input  logic [tts_pkg::IN_DATA_W-1:0]   s_tdata,
	// command[2:0]
	input  logic [2:0]                      s_tuser,
	// Result items
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// task_bits[4:0], event_flags[14:5], tick_count[46:15], zero pad [47]
	output logic [tts_pkg::OUT_DATA_W-1:0]  m_tdata
);

	localparam int IN_USED = $bits(tts_pkg::in_fields_t);

	// Input stage
	logic                 valid_s1;
	tts_pkg::in_fields_t  item_s1;
	logic [2:0]           cmd_s1;

	// Output register
	logic                 out_valid_q;
	tts_pkg::out_fields_t out_q;

	// Scheduler state
	logic                         dw_enable_q;
	logic [tts_pkg::COUNT_W-1:0]  tick_q;
	logic [4:0]                   mod21_q;
	logic [5:0]                   mod50_q;
	logic [tts_pkg::TASK_W-1:0]   tasks_q;
	logic [tts_pkg::FLAG_W-1:0]   flags_q;
	logic [TIMER_WIDTH-1:0]       cd_q [tts_pkg::NUM_CD];

	// Next state
	logic [tts_pkg::COUNT_W-1:0]  tick_d;
	logic [4:0]                   mod21_d;
	logic [5:0]                   mod50_d;
	logic [tts_pkg::TASK_W-1:0]   tasks_d;
	logic [tts_pkg::FLAG_W-1:0]   flags_d;
	logic [TIMER_WIDTH-1:0]       cd_d [tts_pkg::NUM_CD];

	logic                         is_tick;
	logic [tts_pkg::NUM_CD-1:0]   cd_en;
	logic [tts_pkg::NUM_CD-1:0]   cd_hit;
	logic [4:0]                   mod21_inc;
	logic [5:0]                   mod50_inc;
	logic                         mode_dw_ok;
	logic                         mode_scan_ok;
	logic                         advance;
	logic                         out_free;

	assign cfg_ready = 1'b1;

	// The output register can take a result when empty or being drained;
	// the input stage moves whenever it holds an item and that is true.
	assign out_free = !out_valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(tts_pkg::OUT_DATA_W - $bits(tts_pkg::out_fields_t)){1'b0}}, out_q};

	// Phase counters and countdown gates
	always_comb begin
		is_tick   = (cmd_s1 == tts_pkg::CMD_TICK);
		mod21_inc = (mod21_q >= tts_pkg::MOD21_LAST) ? 5'd0 : mod21_q + 5'd1;
		mod50_inc = (mod50_q >= tts_pkg::MOD50_LAST) ? 6'd0 : mod50_q + 6'd1;

		mode_dw_ok = (item_s1.radio_mode == tts_pkg::MODE_FOREGROUND)
			|| (item_s1.radio_mode == tts_pkg::MODE_INCOMING)
			|| (item_s1.radio_mode == tts_pkg::MODE_POWER_SAVE);
		mode_scan_ok = mode_dw_ok || (item_s1.radio_mode == tts_pkg::MODE_RECEIVE);

		cd_en = '0;
		cd_en[tts_pkg::CD_TXTO]  = is_tick && (mod50_inc == 6'd0);
		cd_en[tts_pkg::CD_CDCSS] = is_tick;
		cd_en[tts_pkg::CD_CTCSS] = is_tick;
		cd_en[tts_pkg::CD_SWAIT] = is_tick
			&& (item_s1.radio_mode == tts_pkg::MODE_FOREGROUND);
		cd_en[tts_pkg::CD_SAVE]  = is_tick
			&& (item_s1.radio_mode == tts_pkg::MODE_POWER_SAVE);
		cd_en[tts_pkg::CD_DUALW] = is_tick && !item_s1.scan_active
			&& (item_s1.tone_scan_mode == tts_pkg::TONE_OFF) && dw_enable_q && mode_dw_ok;
		cd_en[tts_pkg::CD_SCANP] = is_tick && mode_scan_ok && (item_s1.scan_active
			|| (item_s1.tone_scan_mode == tts_pkg::TONE_SCANNING));
		cd_en[tts_pkg::CD_TAIL]  = is_tick;
	end

	// Countdown step: decrement when enabled and nonzero, hit on reaching zero
	always_comb begin
		for (int i = 0; i < tts_pkg::NUM_CD; i++) begin
			cd_hit[i] = cd_en[i] && (cd_q[i] == TIMER_WIDTH'(1));
			cd_d[i]   = cd_q[i];
			if (cd_en[i] && (cd_q[i] != '0)) begin
				cd_d[i] = cd_q[i] - TIMER_WIDTH'(1);
			end
		end
		// Load overrides; a load is never a tick so no step collides with it
		if (cmd_s1 == tts_pkg::CMD_LOAD) begin
			cd_d[item_s1.timer_index] = TIMER_WIDTH'(item_s1.load_value);
		end
	end

	// Tasks, flags and tick count
	always_comb begin
		tick_d  = tick_q;
		mod21_d = mod21_q;
		mod50_d = mod50_q;
		tasks_d = tasks_q;
		flags_d = flags_q;
		unique case (cmd_s1)
			tts_pkg::CMD_TICK: begin
				tick_d  = tick_q + 32'd1;
				mod21_d = mod21_inc;
				mod50_d = mod50_inc;
				tasks_d[tts_pkg::TASK_KEYS] = 1'b1;
				tasks_d[tts_pkg::TASK_IRQ]  = 1'b1;
				// Screen task is skipped only while transmitting with no display request
				if (item_s1.radio_mode != tts_pkg::MODE_TRANSMIT || item_s1.display_request) begin
					tasks_d[tts_pkg::TASK_SCREEN] = 1'b1;
				end
				if (tick_d[1:0] == 2'd0) begin
					flags_d[tts_pkg::FLAG_40MS] = 1'b1;
				end
				if (mod21_inc == 5'd0) begin
					tasks_d[tts_pkg::TASK_SCAN] = 1'b1;
				end
				if (mod50_inc == 6'd0) begin
					flags_d[tts_pkg::FLAG_500MS] = 1'b1;
					tasks_d[tts_pkg::TASK_FM]    = 1'b1;
				end
				if (cd_hit[tts_pkg::CD_TXTO]) begin
					flags_d[tts_pkg::FLAG_TXTO] = 1'b1;
				end
				// Tone-found expiry drops both tone flags; cdcss is checked first
				if (cd_hit[tts_pkg::CD_CDCSS] && flags_d[tts_pkg::FLAG_CDCSS]) begin
					flags_d[tts_pkg::FLAG_CDCSS] = 1'b0;
					flags_d[tts_pkg::FLAG_CTCSS] = 1'b0;
				end
				if (cd_hit[tts_pkg::CD_CTCSS] && flags_d[tts_pkg::FLAG_CTCSS]) begin
					flags_d[tts_pkg::FLAG_CDCSS] = 1'b0;
					flags_d[tts_pkg::FLAG_CTCSS] = 1'b0;
				end
				if (cd_hit[tts_pkg::CD_SWAIT]) flags_d[tts_pkg::FLAG_PSAVE]   = 1'b1;
				if (cd_hit[tts_pkg::CD_SAVE])  flags_d[tts_pkg::FLAG_SAVEEXP] = 1'b1;
				if (cd_hit[tts_pkg::CD_DUALW]) flags_d[tts_pkg::FLAG_DUALW]   = 1'b1;
				if (cd_hit[tts_pkg::CD_SCANP]) flags_d[tts_pkg::FLAG_SCANL]   = 1'b1;
				if (cd_hit[tts_pkg::CD_TAIL])  flags_d[tts_pkg::FLAG_TAIL]    = 1'b1;
			end
			tts_pkg::CMD_CLEAR_TASKS: begin
				tasks_d = tasks_q & ~item_s1.bit_mask[tts_pkg::TASK_W-1:0];
			end
			tts_pkg::CMD_CLEAR_FLAGS: begin
				flags_d = flags_q & ~item_s1.bit_mask;
			end
			tts_pkg::CMD_SET_FLAGS: begin
				flags_d = flags_q | item_s1.bit_mask;
			end
			default: begin
				// Load handled with the countdowns; unknown codes change nothing
			end
		endcase
	end

	// Input stage: capture whenever the stage is empty or moving on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1 <= tts_pkg::in_fields_t'(s_tdata[IN_USED-1:0]);
			cmd_s1  <= s_tuser;
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.task_bits   <= tasks_d;
			out_q.event_flags <= flags_d;
			out_q.tick_count  <= tick_d;
		end
	end

	// Scheduler state: commit on each item that moves to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dw_enable_q <= 1'b0;
			tick_q      <= '0;
			mod21_q     <= '0;
			mod50_q     <= '0;
			tasks_q     <= '0;
			flags_q     <= '0;
			for (int i = 0; i < tts_pkg::NUM_CD; i++) begin
				cd_q[i] <= '0;
			end
		end else begin
			if (cfg_valid && cfg_ready) begin
				dw_enable_q <= cfg_data;
			end
			if (advance) begin
				tick_q  <= tick_d;
				mod21_q <= mod21_d;
				mod50_q <= mod50_d;
				tasks_q <= tasks_d;
				flags_q <= flags_d;
				for (int i = 0; i < tts_pkg::NUM_CD; i++) begin
					cd_q[i] <= cd_d[i];
				end
			end
		end
	end

endmodule

/* bench/tick_schedule_checker.sv */
// Scoreboard for the tick task scheduler: tracks the scheduler state from accepted
// command items and compares every result item against the predicted snapshot.
// Depends on tts_pkg for field layouts, command codes and bit positions.
module tick_schedule_checker #(
	parameter int TIMER_W = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic                          cfg_data,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [tts_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic [2:0]                    s_tuser,
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [tts_pkg::OUT_DATA_W-1:0] m_tdata,
	output int                            fail_count,
	output int                            expected_count
);

	logic                        dw_enable;
	logic [tts_pkg::COUNT_W-1:0] ticks;
	logic [4:0]                  phase21;
	logic [5:0]                  phase50;
	logic [tts_pkg::TASK_W-1:0]  tasks;
	logic [tts_pkg::FLAG_W-1:0]  flags;
	logic [TIMER_W-1:0]          countdown [tts_pkg::NUM_CD];
	tts_pkg::out_fields_t        expected_snapshots [$];

	// Decrement a running countdown; report the step that lands on zero.
	function automatic logic count_down(int idx);
		if (countdown[idx] == '0)
			return 1'b0;
		countdown[idx] = countdown[idx] - 1'b1;
		return countdown[idx] == '0;
	endfunction

	function automatic void run_tick(tts_pkg::in_fields_t f);
		logic hit;
		logic dual_mode;
		logic scan_mode;
		ticks = ticks + 1'b1;
		phase21 = (phase21 >= tts_pkg::MOD21_LAST) ? 5'd0 : phase21 + 5'd1;
		phase50 = (phase50 >= tts_pkg::MOD50_LAST) ? 6'd0 : phase50 + 6'd1;

		tasks[tts_pkg::TASK_KEYS] = 1'b1;
		tasks[tts_pkg::TASK_IRQ] = 1'b1;
		if (f.radio_mode != tts_pkg::MODE_TRANSMIT || f.display_request)
			tasks[tts_pkg::TASK_SCREEN] = 1'b1;
		if (ticks[1:0] == 2'b00)
			flags[tts_pkg::FLAG_40MS] = 1'b1;
		if (phase21 == 5'd0)
			tasks[tts_pkg::TASK_SCAN] = 1'b1;
		if (phase50 == 6'd0) begin
			flags[tts_pkg::FLAG_500MS] = 1'b1;
			if (count_down(tts_pkg::CD_TXTO))
				flags[tts_pkg::FLAG_TXTO] = 1'b1;
			tasks[tts_pkg::TASK_FM] = 1'b1;
		end

		// A tone countdown expiring drops both tone flags, but only if its own is up
		hit = count_down(tts_pkg::CD_CDCSS);
		if (hit && flags[tts_pkg::FLAG_CDCSS]) begin
			flags[tts_pkg::FLAG_CDCSS] = 1'b0;
			flags[tts_pkg::FLAG_CTCSS] = 1'b0;
		end
		hit = count_down(tts_pkg::CD_CTCSS);
		if (hit && flags[tts_pkg::FLAG_CTCSS]) begin
			flags[tts_pkg::FLAG_CDCSS] = 1'b0;
			flags[tts_pkg::FLAG_CTCSS] = 1'b0;
		end

		if (f.radio_mode == tts_pkg::MODE_FOREGROUND) begin
			if (count_down(tts_pkg::CD_SWAIT))
				flags[tts_pkg::FLAG_PSAVE] = 1'b1;
		end else if (f.radio_mode == tts_pkg::MODE_POWER_SAVE) begin
			if (count_down(tts_pkg::CD_SAVE))
				flags[tts_pkg::FLAG_SAVEEXP] = 1'b1;
		end

		dual_mode = f.radio_mode == tts_pkg::MODE_FOREGROUND ||
			f.radio_mode == tts_pkg::MODE_INCOMING ||
			f.radio_mode == tts_pkg::MODE_POWER_SAVE;
		scan_mode = dual_mode || f.radio_mode == tts_pkg::MODE_RECEIVE;
		if (!f.scan_active && f.tone_scan_mode == tts_pkg::TONE_OFF && dw_enable &&
				dual_mode) begin
			if (count_down(tts_pkg::CD_DUALW))
				flags[tts_pkg::FLAG_DUALW] = 1'b1;
		end
		if ((f.scan_active || f.tone_scan_mode == tts_pkg::TONE_SCANNING) && scan_mode) begin
			if (count_down(tts_pkg::CD_SCANP))
				flags[tts_pkg::FLAG_SCANL] = 1'b1;
		end
		if (count_down(tts_pkg::CD_TAIL))
			flags[tts_pkg::FLAG_TAIL] = 1'b1;
	endfunction

	function automatic tts_pkg::out_fields_t apply_command(logic [2:0] cmd,
			tts_pkg::in_fields_t f);
		tts_pkg::out_fields_t snap;
		case (cmd)
			tts_pkg::CMD_TICK:        run_tick(f);
			tts_pkg::CMD_LOAD:        countdown[f.timer_index] = TIMER_W'(f.load_value);
			tts_pkg::CMD_CLEAR_TASKS: tasks = tasks & ~f.bit_mask[tts_pkg::TASK_W-1:0];
			tts_pkg::CMD_CLEAR_FLAGS: flags = flags & ~f.bit_mask;
			tts_pkg::CMD_SET_FLAGS:   flags = flags | f.bit_mask;
			default: ;
		endcase
		snap.task_bits = tasks;
		snap.event_flags = flags;
		snap.tick_count = ticks;
		return snap;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		tts_pkg::out_fields_t got;
		tts_pkg::out_fields_t want;
		if (!arst_n) begin
			dw_enable = 1'b0;
			ticks = '0;
			phase21 = '0;
			phase50 = '0;
			tasks = '0;
			flags = '0;
			for (int i = 0; i < tts_pkg::NUM_CD; i++)
				countdown[i] = '0;
			expected_snapshots.delete();
			fail_count = 0;
			expected_count <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				dw_enable = cfg_data;

			if (m_tvalid && m_tready) begin
				got = tts_pkg::out_fields_t'(m_tdata[$bits(tts_pkg::out_fields_t)-1:0]);
				if (expected_snapshots.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result tasks=%h flags=%h ticks=%0d",
							$time, got.task_bits, got.event_flags, got.tick_count);
				end else begin
					want = expected_snapshots.pop_front();
					if (got.task_bits !== want.task_bits ||
					    got.event_flags !== want.event_flags ||
					    got.tick_count !== want.tick_count) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%0t: mismatch exp %h %h %0d got %h %h %0d",
								$time, want.task_bits, want.event_flags,
								want.tick_count, got.task_bits, got.event_flags,
								got.tick_count);
					end
				end
			end

			if (s_tvalid && s_tready)
				expected_snapshots.push_back(apply_command(s_tuser,
					tts_pkg::in_fields_t'(s_tdata[$bits(tts_pkg::in_fields_t)-1:0])));

			expected_count <= int'(expected_snapshots.size());
		end
	end

endmodule

/* bench/tb_tick_task_scheduler_core.sv */
// Top-level bench for tick_task_scheduler_core: clock, reset, command stimulus,
// result back-pressure and the final verdict. Depends on tts_pkg, the core and
// tick_schedule_checker, which does all prediction and comparison.
module tb_tick_task_scheduler_core;

	// Codes the package leaves unnamed but the stimulus still has to reach
	localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
	localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
	localparam logic [2:0] MODE_UNDEFINED = 3'd7;
	localparam logic [1:0] TONE_FOUND     = 2'd2;
	localparam logic [1:0] TONE_RESERVED  = 2'd3;

	localparam int STALL_LIMIT     = 2000;  // quiet cycles before the run is abandoned
	localparam int HOLD_CYCLES     = 300;   // one long receiver hold-off
	localparam int ITEMS_PER_PHASE = 300;
	localparam int IDLE_PERCENT    = 12;

	logic                           clk;
	logic                           arst_n = 1'b0;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic                           cfg_data = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [tts_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [2:0]                     s_tuser = tts_pkg::CMD_TICK;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [tts_pkg::OUT_DATA_W-1:0] m_tdata;

	int fail_count;
	int expected_count;
	int hold_left = 0;
	int quiet_cycles = 0;
	bit steady = 1'b0;          // no idling on either side while set
	bit pressure_go = 1'b0;
	bit pressure_taken = 1'b0;

	// Radio context that persists across items so countdowns get to run down
	logic [2:0] mode_now = tts_pkg::MODE_FOREGROUND;
	logic       scan_now = 1'b0;
	logic [1:0] tone_now = tts_pkg::TONE_OFF;

	tick_task_scheduler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	tick_schedule_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.fail_count     (fail_count),
		.expected_count (expected_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Receiver: random stalls, one long hold-off on request so the core backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (pressure_go && !pressure_taken) begin
			pressure_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Watchdog: give up when no channel has moved an item for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// Present one command item, with optional idle cycles first; return at the
	// edge that accepts it, leaving tvalid up so back-to-back items stay dense.
	task automatic offer(input logic [2:0] cmd, input tts_pkg::in_fields_t f);
		while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= tts_pkg::IN_DATA_W'(f);
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic issue(input logic [2:0] cmd, input logic [2:0] mode, input logic disp,
			input logic scan, input logic [1:0] tone, input int idx,
			input logic [15:0] value, input logic [9:0] mask);
		tts_pkg::in_fields_t f;
		f.radio_mode = mode;
		f.display_request = disp;
		f.scan_active = scan;
		f.tone_scan_mode = tone;
		f.timer_index = 3'(idx);
		f.load_value = value;
		f.bit_mask = mask;
		offer(cmd, f);
	endtask

	// Drop tvalid, wait for every expected result, then let the pipeline go quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_count != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_dw_enable(input logic value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Mostly ticks under a slowly drifting radio context, with short loads so
	// countdowns actually expire, plus mask commands and the odd unknown code.
	task automatic random_command();
		tts_pkg::in_fields_t f;
		logic [2:0] cmd;
		int pick;
		int load_kind;
		if ($urandom_range(9) == 0)
			mode_now = 3'($urandom_range(7));
		if ($urandom_range(15) == 0)
			scan_now = ~scan_now;
		if ($urandom_range(11) == 0)
			tone_now = 2'($urandom_range(3));
		f.radio_mode = mode_now;
		f.display_request = 1'($urandom_range(1));
		f.scan_active = scan_now;
		f.tone_scan_mode = tone_now;
		f.timer_index = 3'($urandom_range(7));
		f.bit_mask = 10'($urandom_range(1023));
		load_kind = $urandom_range(9);
		if (load_kind == 0)
			f.load_value = 16'd0;
		else if (load_kind == 1)
			f.load_value = 16'($urandom_range(65535));
		else if (f.timer_index == 3'(tts_pkg::CD_TXTO))
			f.load_value = 16'($urandom_range(1, 3));
		else
			f.load_value = 16'($urandom_range(1, 12));

		pick = $urandom_range(99);
		if (pick < 55) begin
			cmd = tts_pkg::CMD_TICK;
		end else if (pick < 72) begin
			cmd = tts_pkg::CMD_LOAD;
		end else if (pick < 80) begin
			cmd = tts_pkg::CMD_CLEAR_TASKS;
		end else if (pick < 88) begin
			cmd = tts_pkg::CMD_CLEAR_FLAGS;
		end else if (pick < 96) begin
			cmd = tts_pkg::CMD_SET_FLAGS;
			// keep about half of the sets sparse so expirations stay visible
			if ($urandom_range(1) == 0)
				f.bit_mask = 10'(1 << $urandom_range(9));
		end else begin
			cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		offer(cmd, f);
	endtask

	initial begin : stimulus
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part runs with dual watch enabled
		write_dw_enable(1'b1);

		// Flag masks at both extremes
		issue(tts_pkg::CMD_SET_FLAGS, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h3FF);
		issue(tts_pkg::CMD_CLEAR_FLAGS, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h3FF);

		// Arm every countdown; the save countdown gets the widest value
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TAIL, 16'd1, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_CDCSS, 16'd1, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_CTCSS, 16'd2, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_SWAIT, 16'd1, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_SAVE, 16'hFFFF, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_DUALW, 16'd1, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_SCANP, 16'd1, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd1, 10'h000);
		issue(tts_pkg::CMD_SET_FLAGS, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0,
			10'((1 << tts_pkg::FLAG_CDCSS) | (1 << tts_pkg::FLAG_CTCSS)));

		// Foreground tick: tail, savewait and dual watch expire, cdcss clears both tone flags
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		// Wide clear mask: only the task bits matter
		issue(tts_pkg::CMD_CLEAR_TASKS, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h3FF);
		// Transmit without display request skips the screen task; ctcss expires silently
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_TRANSMIT, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_TRANSMIT, 1, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		// Undefined mode with reserved tone mode gates like transmit
		issue(tts_pkg::CMD_TICK, MODE_UNDEFINED, 0, 1, TONE_RESERVED,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		// Scan active in receive runs the scan pause countdown out
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_RECEIVE, 0, 1, TONE_FOUND,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_SAVE, 16'd2, 10'h000);
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_POWER_SAVE, 0, 0, tts_pkg::TONE_SCANNING,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_POWER_SAVE, 1, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		// Unknown commands leave everything alone, even with every field bit set
		issue(CMD_UNUSED_LO, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		issue(CMD_UNUSED_HI, MODE_UNDEFINED, 1, 1, TONE_RESERVED,
			tts_pkg::CD_TAIL, 16'hFFFF, 10'h3FF);
		// Loading zero stops a countdown without raising anything
		issue(tts_pkg::CMD_LOAD, tts_pkg::MODE_FOREGROUND, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TAIL, 16'd0, 10'h000);
		issue(tts_pkg::CMD_TICK, tts_pkg::MODE_INCOMING, 0, 0, tts_pkg::TONE_OFF,
			tts_pkg::CD_TXTO, 16'd0, 10'h000);
		settle();

		// Random phases alternate the dual watch setting
		for (int p = 0; p < 3; p++) begin
			write_dw_enable(p == 1);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Hold the receiver off once while the sender keeps pushing
				if (p == 0 && n == 100)
					pressure_go <= 1'b1;
				// One long stretch with no idling on either side
				if (p == 2 && n == 0)
					steady <= 1'b1;
				if (p == 2 && n == 150)
					steady <= 1'b0;
				random_command();
			end
			settle();
		end

		repeat (10) @(posedge clk);
		if (fail_count == 0 && expected_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

/* sim.f */
rtl/tts_pkg.sv
rtl/tick_task_scheduler_core.sv
bench/tick_schedule_checker.sv
bench/tb_tick_task_scheduler_core.sv
